[rtl/core/krt_pkg.sv]
// Shared types, constants and key helper functions for the keyed record table.
package krt_pkg;

    localparam int KEY_W        = 56;
    localparam int POWER_W      = 16;
    localparam int SLOT_W       = 4;
    localparam int KEY_BYTES    = KEY_W / 8;
    localparam int SLOTS_DEFAULT = 16;

    // Empty slot marker: a single '0' character in the top byte
    localparam logic [KEY_W-1:0] EMPTY_KEY = {8'h30, {(KEY_W-8){1'b0}}};

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_SORT   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // One table slot
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [POWER_W-1:0] power;
    } entry_t;

    // Cut a key at its first zero byte, counting from the top byte
    function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic             keep;
        logic [7:0]       c;
        r    = '0;
        keep = 1'b1;
        for (int b = KEY_BYTES - 1; b >= 0; b--)
        begin
            c = k[8*b +: 8];
            if (c == 8'h00)
            begin
                keep = 1'b0;
            end
            r[8*b +: 8] = keep ? c : 8'h00;
        end
        return r;
    endfunction

    // Fold upper case ASCII letters to lower case in every byte
    function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic [7:0]       c;
        r = '0;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            c = k[8*b +: 8];
            if (c >= 8'h41 && c <= 8'h5A)
            begin
                c = c + 8'h20;
            end
            r[8*b +: 8] = c;
        end
        return r;
    endfunction

endpackage

[rtl/core/krt_stream_if.sv]
// Command and response channel interfaces of the keyed record table.
interface krt_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  operation;
    logic [krt_pkg::KEY_W-1:0]   plate;
    logic [krt_pkg::POWER_W-1:0] power;

    modport source (output valid, operation, plate, power, input ready);
    modport sink   (input valid, operation, plate, power, output ready);
endinterface

interface krt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [krt_pkg::SLOT_W-1:0]  slot;
    logic [krt_pkg::KEY_W-1:0]   found_plate;
    logic [krt_pkg::POWER_W-1:0] found_power;
    logic                        last;

    modport source (output valid, status, slot, found_plate, found_power, last,
                    input ready);
    modport sink   (input valid, status, slot, found_plate, found_power, last,
                    output ready);
endinterface

[rtl/core/krt_slot_store.sv]
// Slot memory: one write and one registered read per cycle, per-slot valid bits.
module krt_slot_store #(
    parameter int SLOTS = krt_pkg::SLOTS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(SLOTS)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(SLOTS)-1:0] wr_addr,
    input  krt_pkg::entry_t          wr_data,
    output krt_pkg::entry_t          rd_data
);

    krt_pkg::entry_t slot_mem [SLOTS];
    krt_pkg::entry_t rd_data_reg;
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    logic             rd_valid_reg;
    logic             rd_valid_next;

    // Memory array and read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    // Valid bits: a slot never written reads as empty
    always_comb
    begin
        valid_next    = valid_reg;
        rd_valid_next = rd_valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
        if (rd_en)
        begin
            rd_valid_next = valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg
                                  : krt_pkg::entry_t'{key: krt_pkg::EMPTY_KEY, power: '0};

endmodule

[rtl/core/keyed_record_table_with_sort_top.sv]
// Top level of the keyed record table: sequencer, command latch and response register.
//
// Table of SLOTS records (7-character key, 16-bit power) with case-insensitive
// keys; a key of "0" marks an empty slot. One command is taken at a time and
// the command channel is not ready until it has finished. All slots sit in one
// single-port-read memory and the sequencer walks them one slot at a time:
// each slot visit is a read step followed by a compare step, and insert,
// delete and lookup stop early when the key is found. Sort runs an exchange
// sort over the memory, then streams SLOTS results, each slot read and then
// output. A finished result waits in the response register; backpressure
// stalls the sequencer only when the next result is due. No clearing pass is
// needed after reset.
module keyed_record_table_with_sort_top #(
    parameter int SLOTS = krt_pkg::SLOTS_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    krt_cmd_if.sink  cmd,
    krt_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);
    localparam logic [IDX_W-1:0] IDX_OUTER_LAST = IDX_W'(SLOTS - 2);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_SC_RD   = 11'b000_0000_0010,
        S_SC_CK   = 11'b000_0000_0100,
        S_FIN     = 11'b000_0000_1000,
        S_SO_RDI  = 11'b000_0001_0000,
        S_SO_CAPI = 11'b000_0010_0000,
        S_SO_RDJ  = 11'b000_0100_0000,
        S_SO_CMPJ = 11'b000_1000_0000,
        S_SO_WRI  = 11'b001_0000_0000,
        S_EM_RD   = 11'b010_0000_0000,
        S_EM_OUT  = 11'b100_0000_0000
    } state_t;

    typedef struct packed {
        krt_pkg::status_t            status;
        logic [krt_pkg::SLOT_W-1:0]  slot;
        logic [krt_pkg::KEY_W-1:0]   plate;
        logic [krt_pkg::POWER_W-1:0] power;
        logic                        last;
    } rsp_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic match_reg, match_next;
    logic empty_reg, empty_next;
    logic out_valid_reg, out_valid_next;

    // Payload registers
    krt_pkg::op_t               op_reg, op_next;
    logic [krt_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [krt_pkg::KEY_W-1:0]  fold_reg, fold_next;
    logic [krt_pkg::POWER_W-1:0] power_reg, power_next;
    logic [IDX_W-1:0]           match_idx_reg, match_idx_next;
    logic [IDX_W-1:0]           empty_idx_reg, empty_idx_next;
    krt_pkg::entry_t            match_ent_reg, match_ent_next;
    krt_pkg::entry_t            hold_reg, hold_next;
    rsp_t                       out_reg, out_next;

    // Memory port
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    krt_pkg::entry_t  wr_data;
    krt_pkg::entry_t  rd_data;

    logic cmd_fire;
    logic out_free;
    logic key_hit;
    logic slot_empty;
    logic swap;

    krt_slot_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Shared comparator inputs
    assign key_hit    = (krt_pkg::fold_key(rd_data.key) == fold_reg);
    assign slot_empty = (rd_data.key == krt_pkg::EMPTY_KEY);
    assign swap       = (krt_pkg::fold_key(hold_reg.key) > krt_pkg::fold_key(rd_data.key));

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        match_next     = match_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        fold_next      = fold_reg;
        power_next     = power_reg;
        match_idx_next = match_idx_reg;
        empty_idx_next = empty_idx_reg;
        match_ent_next = match_ent_reg;
        hold_next      = hold_reg;
        out_next       = out_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = hold_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next    = krt_pkg::op_t'(cmd.operation);
                    key_next   = krt_pkg::trim_key(cmd.plate);
                    fold_next  = krt_pkg::fold_key(krt_pkg::trim_key(cmd.plate));
                    power_next = cmd.power;
                    idx_next   = '0;
                    match_next = 1'b0;
                    empty_next = 1'b0;
                    if (krt_pkg::op_t'(cmd.operation) == krt_pkg::OP_SORT)
                    begin
                        state_next = S_SO_RDI;
                    end
                    else
                    begin
                        state_next = S_SC_RD;
                    end
                end
            end

            // Key scan: read one slot, then compare it
            S_SC_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_SC_CK;
            end

            S_SC_CK:
            begin
                if (slot_empty && !empty_reg)
                begin
                    empty_next     = 1'b1;
                    empty_idx_next = idx_reg;
                end
                if (key_hit)
                begin
                    match_next     = 1'b1;
                    match_idx_next = idx_reg;
                    match_ent_next = rd_data;
                    state_next     = S_FIN;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SC_RD;
                end
            end

            // Result and table update for insert, delete, lookup
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.last  = 1'b1;
                    out_next.status = krt_pkg::ST_DONE;
                    out_next.slot  = krt_pkg::SLOT_W'(match_idx_reg);
                    out_next.plate = match_ent_reg.key;
                    out_next.power = match_ent_reg.power;
                    if (op_reg == krt_pkg::OP_INSERT)
                    begin
                        if (match_reg)
                        begin
                            out_next.status = krt_pkg::ST_PRESENT;
                        end
                        else if (empty_reg)
                        begin
                            out_next.slot  = krt_pkg::SLOT_W'(empty_idx_reg);
                            out_next.plate = key_reg;
                            out_next.power = power_reg;
                            wr_en          = 1'b1;
                            wr_addr        = empty_idx_reg;
                            wr_data        = '{key: key_reg, power: power_reg};
                        end
                        else
                        begin
                            out_next.status = krt_pkg::ST_FULL;
                            out_next.slot   = '0;
                            out_next.plate  = '0;
                            out_next.power  = '0;
                        end
                    end
                    else if (!match_reg)
                    begin
                        out_next.status = krt_pkg::ST_MISSING;
                        out_next.slot   = '0;
                        out_next.plate  = '0;
                        out_next.power  = '0;
                    end
                    else if (op_reg == krt_pkg::OP_DELETE)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = match_idx_reg;
                        wr_data = '{key: krt_pkg::EMPTY_KEY, power: '0};
                    end
                    state_next = S_IDLE;
                end
            end

            // Exchange sort: slot i lives in hold_reg while j sweeps above it
            S_SO_RDI:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_SO_CAPI;
            end

            S_SO_CAPI:
            begin
                hold_next  = rd_data;
                j_next     = idx_reg + 1'b1;
                state_next = S_SO_RDJ;
            end

            S_SO_RDJ:
            begin
                rd_en      = 1'b1;
                rd_addr    = j_reg;
                state_next = S_SO_CMPJ;
            end

            S_SO_CMPJ:
            begin
                if (swap)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = j_reg;
                    wr_data   = hold_reg;
                    hold_next = rd_data;
                end
                if (j_reg == IDX_LAST)
                begin
                    state_next = S_SO_WRI;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_SO_RDJ;
                end
            end

            S_SO_WRI:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = hold_reg;
                if (idx_reg == IDX_OUTER_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_EM_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SO_RDI;
                end
            end

            // List every slot in index order
            S_EM_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_EM_OUT;
            end

            S_EM_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next.status = krt_pkg::ST_DONE;
                    out_next.slot   = krt_pkg::SLOT_W'(idx_reg);
                    out_next.plate  = rd_data.key;
                    out_next.power  = rd_data.power;
                    out_next.last   = (idx_reg == IDX_LAST);
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_EM_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            j_reg         <= '0;
            match_reg     <= 1'b0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            j_reg         <= j_next;
            match_reg     <= match_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        fold_reg      <= fold_next;
        power_reg     <= power_next;
        match_idx_reg <= match_idx_next;
        empty_idx_reg <= empty_idx_next;
        match_ent_reg <= match_ent_next;
        hold_reg      <= hold_next;
        out_reg       <= out_next;
    end

    // Response channel
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.slot        = out_reg.slot;
    assign rsp.found_plate = out_reg.plate;
    assign rsp.found_power = out_reg.power;
    assign rsp.last        = out_reg.last;

    // Checks
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> !cmd.ready)
        else $error("command channel ready right after taking an item");

    a_error_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != krt_pkg::ST_DONE) |-> rsp.last)
        else $error("error response not marked last");

    a_error_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && ((rsp.status == krt_pkg::ST_MISSING) || (rsp.status == krt_pkg::ST_FULL))
        |-> (rsp.slot == '0) && (rsp.found_plate == '0) && (rsp.found_power == '0))
        else $error("missing or full response carries slot data");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("table written while idle");

endmodule
